[hdl/mdio_mfm_pkg.sv]
// Package for the clause 22 management frame master.
// Holds the word types, action and fail codes and the frame constants.
// No dependencies.
package mdio_mfm_pkg;

    typedef struct packed {
        logic [1:0]  action;
        logic [4:0]  phy_address;
        logic [4:0]  register_address;
        logic [15:0] write_data;
        logic        line_in;
    } in_word_t;

    typedef struct packed {
        logic        line_out;
        logic        line_drive;
        logic        mgmt_clock;
        logic        busy_res;
        logic        done_res;
        logic        ok;
        logic [1:0]  fail_reason;
        logic [15:0] read_data;
    } out_word_t;

    localparam logic [1:0] ACT_TICK  = 2'd0;
    localparam logic [1:0] ACT_READ  = 2'd1;
    localparam logic [1:0] ACT_WRITE = 2'd2;

    localparam logic [1:0] FAIL_NONE     = 2'd0;
    localparam logic [1:0] FAIL_PREAMBLE = 2'd1;
    localparam logic [1:0] FAIL_TURN     = 2'd2;
    localparam logic [1:0] FAIL_RELEASE  = 2'd3;

    // Start 01, opcode 10 for read; start 01, opcode 01, turnaround 10 for write
    localparam logic [31:0] FRAME_READ_BASE  = 32'h6000_0000;
    localparam logic [31:0] FRAME_WRITE_BASE = 32'h5002_0000;

    localparam logic [5:0] READ_CMD_BITS    = 6'd14;
    localparam logic [5:0] DATA_BITS        = 6'd16;
    localparam logic [5:0] WRITE_FRAME_BITS = 6'd32;

endpackage

[hdl/mdio_mfm_in_if.sv]
// Request channel of the management frame master: valid/ready plus one word.
// Depends on mdio_mfm_pkg.
interface mdio_mfm_in_if;
    logic                  valid;
    logic                  ready;
    mdio_mfm_pkg::in_word_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

[hdl/mdio_mfm_out_if.sv]
// Result channel of the management frame master: valid/ready plus one word.
// Depends on mdio_mfm_pkg.
interface mdio_mfm_out_if;
    logic                   valid;
    logic                   ready;
    mdio_mfm_pkg::out_word_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

[hdl/mdio_mfm_engine.sv]
// Frame sequencer: phase, bit counter and shift registers of one transfer.
// Computes the result word for the request word offered this cycle.
// Depends on mdio_mfm_pkg.
module mdio_mfm_engine #(
    parameter int PREAMBLE_BITS = 32
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    step,
    input  mdio_mfm_pkg::in_word_t  word,
    output mdio_mfm_pkg::out_word_t result
);

    typedef enum logic [2:0] {
        PH_IDLE     = 3'd0,
        PH_PREAMBLE = 3'd1,
        PH_COMMAND  = 3'd2,
        PH_TURN     = 3'd3,
        PH_DATA     = 3'd4,
        PH_RELEASE  = 3'd5
    } phase_t;

    localparam logic [5:0] PRE_LAST = 6'(PREAMBLE_BITS);

    phase_t      phase_reg, phase_next, phase_cur;
    logic        is_write_reg, is_write_next;
    logic [5:0]  bit_count_reg, bit_count_next;
    logic [31:0] out_shift_reg, out_shift_next;
    logic [15:0] in_shift_reg, in_shift_next;
    logic [5:0]  count_inc;
    logic [5:0]  cmd_last;

    assign count_inc = bit_count_reg + 6'd1;
    assign cmd_last  = is_write_reg ? mdio_mfm_pkg::WRITE_FRAME_BITS
                                    : mdio_mfm_pkg::READ_CMD_BITS;

    always_comb
    begin
        // Treat a phase code with no meaning as idle
        case (phase_reg)
            PH_IDLE, PH_PREAMBLE, PH_COMMAND, PH_TURN, PH_DATA, PH_RELEASE:
                phase_cur = phase_reg;
            default:
                phase_cur = PH_IDLE;
        endcase
    end

    always_comb
    begin
        result         = '0;
        phase_next     = phase_cur;
        is_write_next  = is_write_reg;
        bit_count_next = bit_count_reg;
        out_shift_next = out_shift_reg;
        in_shift_next  = in_shift_reg;

        case (word.action)
            mdio_mfm_pkg::ACT_READ, mdio_mfm_pkg::ACT_WRITE:
            begin
                result.busy_res = 1'b1;
                if (phase_cur == PH_IDLE)
                begin
                    is_write_next = (word.action == mdio_mfm_pkg::ACT_WRITE);
                    out_shift_next = (is_write_next ? mdio_mfm_pkg::FRAME_WRITE_BASE
                                                    : mdio_mfm_pkg::FRAME_READ_BASE)
                                   | (32'(word.phy_address) << 23)
                                   | (32'(word.register_address) << 18)
                                   | (is_write_next ? 32'(word.write_data) : 32'd0);
                    in_shift_next  = '0;
                    bit_count_next = '0;
                    phase_next     = PH_PREAMBLE;
                end
            end
            mdio_mfm_pkg::ACT_TICK:
            begin
                if (phase_cur != PH_IDLE)
                begin
                    result.mgmt_clock = 1'b1;
                    result.busy_res   = 1'b1;
                    case (phase_cur)
                        PH_PREAMBLE:
                        begin
                            result.line_out   = 1'b1;
                            result.line_drive = 1'b1;
                            bit_count_next    = count_inc;
                            if (count_inc >= PRE_LAST)
                            begin
                                bit_count_next = '0;
                                if (!word.line_in)
                                begin
                                    result.busy_res    = 1'b0;
                                    result.done_res    = 1'b1;
                                    result.fail_reason = mdio_mfm_pkg::FAIL_PREAMBLE;
                                    result.read_data   = is_write_reg ? 16'd0 : in_shift_reg;
                                    phase_next         = PH_IDLE;
                                end
                                else
                                begin
                                    phase_next = PH_COMMAND;
                                end
                            end
                        end
                        PH_COMMAND:
                        begin
                            result.line_out   = out_shift_reg[31];
                            result.line_drive = 1'b1;
                            out_shift_next    = {out_shift_reg[30:0], 1'b0};
                            bit_count_next    = count_inc;
                            if (count_inc >= cmd_last)
                            begin
                                phase_next     = is_write_reg ? PH_RELEASE : PH_TURN;
                                bit_count_next = '0;
                            end
                        end
                        PH_TURN:
                        begin
                            if (word.line_in)
                            begin
                                result.busy_res    = 1'b0;
                                result.done_res    = 1'b1;
                                result.fail_reason = mdio_mfm_pkg::FAIL_TURN;
                                result.read_data   = is_write_reg ? 16'd0 : in_shift_reg;
                                phase_next         = PH_IDLE;
                                bit_count_next     = '0;
                            end
                            else
                            begin
                                phase_next = PH_DATA;
                            end
                        end
                        PH_DATA:
                        begin
                            in_shift_next  = {in_shift_reg[14:0], word.line_in};
                            bit_count_next = count_inc;
                            if (count_inc >= mdio_mfm_pkg::DATA_BITS)
                            begin
                                phase_next     = PH_RELEASE;
                                bit_count_next = '0;
                            end
                        end
                        default:
                        begin
                            // Trailing release period: line must read high
                            result.busy_res    = 1'b0;
                            result.done_res    = 1'b1;
                            result.ok          = word.line_in;
                            result.fail_reason = word.line_in ? mdio_mfm_pkg::FAIL_NONE
                                                              : mdio_mfm_pkg::FAIL_RELEASE;
                            result.read_data   = is_write_reg ? 16'd0 : in_shift_reg;
                            phase_next         = PH_IDLE;
                            bit_count_next     = '0;
                        end
                    endcase
                end
            end
            default:
            begin
                result.busy_res = (phase_cur != PH_IDLE);
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            is_write_reg  <= 1'b0;
            bit_count_reg <= '0;
            out_shift_reg <= '0;
            in_shift_reg  <= '0;
        end
        else if (step)
        begin
            phase_reg     <= phase_next;
            is_write_reg  <= is_write_next;
            bit_count_reg <= bit_count_next;
            out_shift_reg <= out_shift_next;
            in_shift_reg  <= in_shift_next;
        end
    end

endmodule

[hdl/mdio_management_frame_master_top.sv]
// Clause 22 management frame master, top level.
// The result word of an accepted request word is registered and offered in the next cycle.
// Throughput: one word per cycle; the output register takes a new result
// whenever it is empty or its word is taken in the same cycle.
// Reset (rst_n low, asynchronous): phase idle, counters cleared, no result held.
// Depends on mdio_mfm_pkg, mdio_mfm_in_if, mdio_mfm_out_if, mdio_mfm_engine.
module mdio_management_frame_master_top #(
    parameter int PREAMBLE_BITS = 32
) (
    input  logic           clk,
    input  logic           rst_n,
    mdio_mfm_in_if.sink    req,
    mdio_mfm_out_if.source rsp
);

    logic                    accept;
    logic                    out_valid_reg;
    mdio_mfm_pkg::out_word_t out_word_reg;
    mdio_mfm_pkg::out_word_t step_result;

    assign req.ready = !out_valid_reg || rsp.ready;
    assign accept    = req.valid && req.ready;

    mdio_mfm_engine #(
        .PREAMBLE_BITS(PREAMBLE_BITS)
    ) u_engine (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (accept),
        .word   (req.data),
        .result (step_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_word_reg <= step_result;
        end
    end

    assign rsp.valid = out_valid_reg;
    assign rsp.data  = out_word_reg;

endmodule
